>>> sv/bdws_pkg.sv
// Shared types and constants for the bounded deque with sort.
package bdws_pkg;

  localparam int DATA_W       = 32;
  localparam int ACT_W        = 3;
  localparam int STAT_W       = 2;
  localparam int CAPACITY_DEF = 32;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_SHOW       = 3'd4,
    ACT_SORT       = 3'd5,
    ACT_CLEAR      = 3'd6,
    ACT_NOP        = 3'd7
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SHOW,
    S_SORT
  } state_t;

  typedef enum logic [2:0] {
    C_HOLD,
    C_LEFT,
    C_RIGHT,
    C_HEAD,
    C_PUSH,
    C_MIN,
    C_MAX
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     left_gt;
  } cell_ctl_t;

endpackage

>>> sv/bdws_cell.sv
// One storage cell of the deque row: holds one element, exchanges with neighbors.
module bdws_cell
  import bdws_pkg::*;
(
  input  logic                     clk,
  input  cell_ctl_t                ctl,
  input  logic signed [DATA_W-1:0] left_data,
  input  logic signed [DATA_W-1:0] right_data,
  input  logic signed [DATA_W-1:0] head_data,
  input  logic signed [DATA_W-1:0] push_data,
  output logic signed [DATA_W-1:0] data,
  output logic                     gt
);

  logic signed [DATA_W-1:0] data_next;

  assign gt = data > right_data;

  always_comb begin
    case (ctl.op)
      C_LEFT:  data_next = left_data;
      C_RIGHT: data_next = right_data;
      C_HEAD:  data_next = head_data;
      C_PUSH:  data_next = push_data;
      C_MIN:   data_next = gt ? right_data : data;
      C_MAX:   data_next = ctl.left_gt ? left_data : data;
      default: data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

>>> sv/bounded_deque_with_sort.sv
// Top level: bounded deque of signed words held in a row of cells, with in-place sort.
// Push, pop, clear and unused codes: result registered the next cycle after acceptance.
// Show on N elements: N results, one per cycle while the output is not stalled, as the row rotates past the head cell.
// Sort on N elements: N odd-even compare/exchange passes over the cell row, one per cycle.
// An item is accepted only when the sequencer is idle and the output register is free.
// Reset (rst, synchronous) clears count, sequencer and output valid; cell contents undefined.
module bounded_deque_with_sort
  import bdws_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [ACT_W-1:0]         action,
  input  logic signed [DATA_W-1:0] value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] element,
  output logic [STAT_W-1:0]        status,
  output logic                     last
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  state_t             state, state_next;
  logic [CNT_W-1:0]   count, count_next;
  logic [CNT_W-1:0]   step, step_next;
  logic               out_valid_next;
  logic signed [DATA_W-1:0] element_next;
  logic [STAT_W-1:0]  status_next;
  logic               last_next;

  logic signed [DATA_W-1:0] cell_data [CAPACITY];
  logic                     cell_gt   [CAPACITY];
  cell_ctl_t                cell_ctl  [CAPACITY];
  cell_op_t                 cell_op   [CAPACITY];

  logic out_free;
  logic accept;
  logic full;
  logic empty;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = !(state == S_IDLE && out_free);
  assign accept   = in_valid && !in_stall;
  assign full     = count == CNT_W'(CAPACITY);
  assign empty    = count == '0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [DATA_W-1:0] left_d;
    logic signed [DATA_W-1:0] right_d;

    if (g == 0) begin : g_first
      assign left_d = value;
      assign cell_ctl[g] = '{op: cell_op[g], left_gt: 1'b0};
    end else begin : g_mid
      assign left_d = cell_data[g-1];
      assign cell_ctl[g] = '{op: cell_op[g], left_gt: cell_gt[g-1]};
    end

    if (g == CAPACITY - 1) begin : g_end
      assign right_d = '0;
    end else begin : g_inner
      assign right_d = cell_data[g+1];
    end

    bdws_cell u_cell (
      .clk        (clk),
      .ctl        (cell_ctl[g]),
      .left_data  (left_d),
      .right_data (right_d),
      .head_data  (cell_data[0]),
      .push_data  (value),
      .data       (cell_data[g]),
      .gt         (cell_gt[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    element <= element_next;
    status  <= status_next;
    last    <= last_next;
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    step_next      = step;
    out_valid_next = out_valid && out_stall;
    element_next   = element;
    status_next    = status;
    last_next      = last;
    for (int i = 0; i < CAPACITY; i++) begin
      cell_op[i] = C_HOLD;
    end

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          out_valid_next = 1'b1;
          element_next   = '0;
          status_next    = ST_OK;
          last_next      = 1'b1;
          unique case (action_t'(action))
            ACT_PUSH_FRONT: begin
              if (full) begin
                status_next = ST_FULL;
              end else begin
                for (int i = 0; i < CAPACITY; i++) begin
                  cell_op[i] = (i == 0) ? C_PUSH : C_LEFT;
                end
                count_next = count + CNT_W'(1);
              end
            end
            ACT_PUSH_BACK: begin
              if (full) begin
                status_next = ST_FULL;
              end else begin
                for (int i = 0; i < CAPACITY; i++) begin
                  if (CNT_W'(i) == count) cell_op[i] = C_PUSH;
                end
                count_next = count + CNT_W'(1);
              end
            end
            ACT_POP_FRONT: begin
              if (empty) begin
                status_next = ST_EMPTY;
              end else begin
                for (int i = 0; i < CAPACITY; i++) begin
                  cell_op[i] = C_RIGHT;
                end
                count_next = count - CNT_W'(1);
              end
            end
            ACT_POP_BACK: begin
              if (empty) status_next = ST_EMPTY;
              else count_next = count - CNT_W'(1);
            end
            ACT_SHOW: begin
              if (empty) begin
                status_next = ST_EMPTY;
              end else begin
                out_valid_next = 1'b0;
                step_next      = '0;
                state_next     = S_SHOW;
              end
            end
            ACT_SORT: begin
              if (empty) begin
                status_next = ST_EMPTY;
              end else begin
                step_next  = '0;
                state_next = S_SORT;
              end
            end
            ACT_CLEAR: begin
              if (empty) status_next = ST_EMPTY;
              else count_next = '0;
            end
            default: ;
          endcase
        end
      end

      S_SHOW: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          element_next   = cell_data[0];
          status_next    = ST_OK;
          last_next      = (step + CNT_W'(1)) == count;
          for (int i = 0; i < CAPACITY; i++) begin
            if (CNT_W'(i + 1) == count) cell_op[i] = C_HEAD;
            else if (CNT_W'(i + 1) < count) cell_op[i] = C_RIGHT;
          end
          step_next = step + CNT_W'(1);
          if ((step + CNT_W'(1)) == count) state_next = S_IDLE;
        end
      end

      S_SORT: begin
        for (int i = 0; i < CAPACITY - 1; i++) begin
          if ((i % 2) == int'(step[0]) && CNT_W'(i + 1) < count) begin
            cell_op[i]     = C_MIN;
            cell_op[i + 1] = C_MAX;
          end
        end
        step_next = step + CNT_W'(1);
        if ((step + CNT_W'(1)) == count) state_next = S_IDLE;
      end

      default: state_next = S_IDLE;
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("count above capacity");

  a_busy_stalls: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall)
    else $error("input not stalled while busy");

  a_walk_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (count != '0 && step < count))
    else $error("walk step out of range");

  a_show_last_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHOW && out_free && (step + CNT_W'(1)) == count) |=>
      (state == S_IDLE && out_valid && last))
    else $error("show did not end with last");

endmodule

>>> tb/tb_bounded_deque_with_sort.sv
// Testbench for the bounded deque with sort: directed, random and backpressure tests.
module tb_bounded_deque_with_sort;
  import bdws_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP = CAPACITY_DEF;

  typedef struct packed {
    logic signed [DATA_W-1:0] element;
    logic [STAT_W-1:0]        status;
    logic                     last;
  } deque_result_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [ACT_W-1:0]         action = '0;
  logic signed [DATA_W-1:0] value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] element;
  logic [STAT_W-1:0]        status;
  logic                     last;

  // shadow copy of the deque
  logic signed [DATA_W-1:0] shadow_store [CAP];
  int                       shadow_front = 0;
  int                       shadow_count = 0;

  deque_result_t            pending_results [$];
  int                       mismatches = 0;
  int                       items_sent = 0;
  int                       results_seen = 0;
  int                       peak_count = 0;
  int                       full_drops = 0;

  int                       tx_max_gap = 8;
  int                       rx_max_gap = 8;
  int                       rx_hold = 0;

  bounded_deque_with_sort u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .element   (element),
    .status    (status),
    .last      (last)
  );

  initial forever #6 clk = ~clk;

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic void expect_single(status_t st);
    deque_result_t r;
    r.element = '0;
    r.status  = st;
    r.last    = 1'b1;
    pending_results.push_back(r);
  endfunction

  function automatic void predict_deque(action_t act, logic signed [DATA_W-1:0] val);
    deque_result_t            r;
    logic signed [DATA_W-1:0] tmp;
    int                       pi;
    int                       pj;
    case (act)
      ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
        if (shadow_count >= CAP) begin
          full_drops++;
          expect_single(ST_FULL);
        end else begin
          if (act == ACT_PUSH_FRONT) begin
            shadow_front = (shadow_front + CAP - 1) % CAP;
            shadow_store[shadow_front] = val;
          end else begin
            shadow_store[(shadow_front + shadow_count) % CAP] = val;
          end
          shadow_count++;
          if (shadow_count > peak_count) peak_count = shadow_count;
          expect_single(ST_OK);
        end
      end
      ACT_POP_FRONT, ACT_POP_BACK, ACT_SHOW, ACT_SORT, ACT_CLEAR: begin
        if (shadow_count == 0) begin
          expect_single(ST_EMPTY);
        end else begin
          case (act)
            ACT_POP_FRONT: begin
              shadow_front = (shadow_front + 1) % CAP;
              shadow_count--;
              expect_single(ST_OK);
            end
            ACT_POP_BACK: begin
              shadow_count--;
              expect_single(ST_OK);
            end
            ACT_SHOW: begin
              for (int i = 0; i < shadow_count; i++) begin
                r.element = shadow_store[(shadow_front + i) % CAP];
                r.status  = ST_OK;
                r.last    = (i + 1 == shadow_count);
                pending_results.push_back(r);
              end
            end
            ACT_SORT: begin
              for (int i = 0; i < shadow_count; i++) begin
                for (int j = i + 1; j < shadow_count; j++) begin
                  pi = (shadow_front + i) % CAP;
                  pj = (shadow_front + j) % CAP;
                  if (shadow_store[pi] > shadow_store[pj]) begin
                    tmp = shadow_store[pi];
                    shadow_store[pi] = shadow_store[pj];
                    shadow_store[pj] = tmp;
                  end
                end
              end
              expect_single(ST_OK);
            end
            default: begin
              shadow_count = 0;
              shadow_front = 0;
              expect_single(ST_OK);
            end
          endcase
        end
      end
      default: expect_single(ST_OK);
    endcase
  endfunction

  // leaves in_valid high; callers lower it through wait_drain
  task automatic send_item(action_t act, logic signed [DATA_W-1:0] val);
    int gap;
    gap = $urandom_range(0, tx_max_gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    value    <= val;
    do @(posedge clk); while (in_stall);
    items_sent++;
    predict_deque(act, val);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return $signed($urandom_range(0, 20)) - 10;
      default: return $signed($urandom);
    endcase
  endfunction

  function automatic action_t pick_action();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return ACT_PUSH_BACK;
    if (r < 50) return ACT_PUSH_FRONT;
    if (r < 62) return ACT_POP_FRONT;
    if (r < 74) return ACT_POP_BACK;
    if (r < 84) return ACT_SHOW;
    if (r < 91) return ACT_SORT;
    if (r < 95) return ACT_CLEAR;
    return ACT_NOP;
  endfunction

  // receiver pacing
  initial begin : rx_pacing
    int n;
    forever begin
      if (rx_hold > 0) begin
        out_stall <= 1'b1;
        repeat (rx_hold) @(posedge clk);
        rx_hold = 0;
      end
      n = $urandom_range(0, rx_max_gap);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid && rx_hold == 0) @(posedge clk);
    end
  end

  always @(posedge clk) begin : result_check
    deque_result_t r;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("unexpected result: element %0d status %0d last %0b", element, status, last);
        mismatches++;
      end else begin
        r = pending_results.pop_front();
        if (element !== r.element) begin
          $error("element: expected %0d, got %0d", r.element, element);
          mismatches++;
        end
        if (status !== r.status) begin
          $error("status: expected %0d, got %0d", r.status, status);
          mismatches++;
        end
        if (last !== r.last) begin
          $error("last: expected %0b, got %0b", r.last, last);
          mismatches++;
        end
      end
    end
  end

  task automatic test_empty_and_edges();
    send_item(ACT_POP_FRONT, 32'sd0);
    send_item(ACT_POP_BACK, 32'sd0);
    send_item(ACT_SHOW, 32'sd0);
    send_item(ACT_SORT, 32'sd0);
    send_item(ACT_CLEAR, 32'sd0);
    send_item(ACT_NOP, 32'sh7fff_ffff);
    send_item(ACT_PUSH_BACK, 32'sh7fff_ffff);
    send_item(ACT_PUSH_FRONT, 32'sh8000_0000);
    send_item(ACT_PUSH_BACK, 32'sd0);
    send_item(ACT_PUSH_FRONT, -32'sd1);
    send_item(ACT_PUSH_BACK, 32'sd1);
    send_item(ACT_SHOW, 32'sd0);
    send_item(ACT_SORT, 32'sd0);
    send_item(ACT_SHOW, 32'sd0);
    send_item(ACT_POP_FRONT, 32'sd0);
    send_item(ACT_POP_BACK, 32'sd0);
    send_item(ACT_SHOW, 32'sd0);
    send_item(ACT_POP_FRONT, 32'sd0);
    send_item(ACT_POP_BACK, 32'sd0);
    send_item(ACT_POP_BACK, 32'sd0);
    send_item(ACT_PUSH_FRONT, 32'sd5);
    send_item(ACT_CLEAR, 32'sd0);
    send_item(ACT_SHOW, 32'sd0);
    wait_drain();
  endtask

  task automatic test_random_mix(int num_items, int tx_gap, int rx_gap);
    action_t act;
    tx_max_gap = tx_gap;
    rx_max_gap = rx_gap;
    repeat (num_items) begin
      act = pick_action();
      send_item(act, pick_value());
    end
    wait_drain();
  endtask

  task automatic test_full_under_backpressure();
    tx_max_gap = 0;
    rx_max_gap = 2;
    send_item(ACT_CLEAR, 32'sd0);
    rx_hold = 150;
    for (int i = 0; i < CAP + 2; i++)
      send_item(i[0] ? ACT_PUSH_FRONT : ACT_PUSH_BACK, pick_value());
    send_item(ACT_SHOW, 32'sd0);
    send_item(ACT_SORT, 32'sd0);
    send_item(ACT_SHOW, 32'sd0);
    send_item(ACT_POP_FRONT, 32'sd0);
    send_item(ACT_POP_BACK, 32'sd0);
    send_item(ACT_PUSH_FRONT, 32'sh8000_0000);
    send_item(ACT_SHOW, 32'sd0);
    send_item(ACT_CLEAR, 32'sd0);
    wait_drain();
  endtask

  initial begin : run_tests
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_and_edges();
    test_random_mix(15, 8, 8);
    test_random_mix(15, 0, 0);
    test_full_under_backpressure();
    test_random_mix(15, 8, 3);
    repeat (8) @(posedge clk);
    $display("Sent %0d items, checked %0d results; peak occupancy %0d, %0d pushes dropped full.",
             items_sent, results_seen, peak_count, full_drops);
    $display("Covered empty, full, wraparound, show, sort, clear and long output backpressure.");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      if (pending_results.size() != 0)
        $error("%0d expected results never arrived", pending_results.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
